FILE: design/rgba_3x3_blur_stream_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the RGBA 3x3 blur stream
// Concurrent checks on the clk / rst_n domain of the block; ASSERT_OFF
// removes them.
// ----------------------------------------------------------------------------
`ifndef RGBA_3X3_BLUR_STREAM_MACROS_SVH
`define RGBA_3X3_BLUR_STREAM_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked outside reset.
`define RBS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rgba_3x3_blur_stream: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RBS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rgba_3x3_blur_stream: next-cycle check failed");

`else

`define RBS_ASSERT_NOW(lbl, ante, cons)
`define RBS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: design/rbs_pkg.sv
// ----------------------------------------------------------------------------
// RGBA 3x3 blur stream package
// Shared constants, pixel and control types and the per-channel kernel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rbs_pkg;

  // Default frame store limits.
  localparam int unsigned RBS_MAX_WIDTH  = 2048;
  localparam int unsigned RBS_MAX_HEIGHT = 2048;

  // Configuration port.
  localparam int unsigned CFG_W     = 12;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

  // Ceiling of 65536/5: (x * RECIP_FIVE) >> 16 equals x / 5 for x below 16384.
  localparam logic [13:0] RECIP_FIVE = 14'd13108;

  // Packed pixel: red in the low byte, alpha in the high byte.
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  // What the frame position says about one item.
  typedef struct packed {
    logic emit;      // the item produces a result
    logic last;      // the result closes the frame
    logic interior;  // the result is blurred rather than passed through
  } item_ctrl_t;

  // One channel of the kernel: floor((corners + 4*edges + 20*centre) / 40).
  // The sum tops out at 10200, so it is divided by 8 with a shift and by 5
  // with a reciprocal multiply.
  function automatic logic [7:0] blur_chan(
    input logic [7:0] p0, input logic [7:0] p1, input logic [7:0] p2,
    input logic [7:0] p3, input logic [7:0] p4, input logic [7:0] p5,
    input logic [7:0] p6, input logic [7:0] p7, input logic [7:0] p8
  );
    logic [13:0] corners;
    logic [13:0] edges;
    logic [13:0] sum;
    logic [10:0] eighth;
    logic [24:0] prod;
    corners = 14'(p0) + 14'(p2) + 14'(p6) + 14'(p8);
    edges   = 14'(p1) + 14'(p3) + 14'(p5) + 14'(p7);
    sum     = corners + (edges << 2) + (14'(p4) << 4) + (14'(p4) << 2);
    eighth  = sum[13:3];
    prod    = 25'(eighth) * 25'(RECIP_FIVE);
    return prod[23:16];
  endfunction

endpackage

FILE: design/rbs_frame_pos.sv
// ----------------------------------------------------------------------------
// RGBA 3x3 blur stream: frame position
// Holds the frame size registers and the column and row of the next item,
// and classifies each accepted item as silent, border or interior.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbs_frame_pos import rbs_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = RBS_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = RBS_MAX_HEIGHT,
  localparam int unsigned CB = $clog2(MAX_WIDTH),
  localparam int unsigned WB = $clog2(MAX_WIDTH + 1),
  localparam int unsigned HB = $clog2(MAX_HEIGHT + 1),
  localparam int unsigned RB = $clog2(MAX_HEIGHT + 2)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 accept,
  output logic [CB-1:0]        col,
  output item_ctrl_t           ctrl
);

  logic [CFG_W-1:0] frame_width_r, frame_width_nxt;
  logic [CFG_W-1:0] frame_height_r, frame_height_nxt;
  logic [CB-1:0]    col_r, col_nxt;
  logic [RB-1:0]    row_r, row_nxt;

  logic [WB-1:0] w_eff;
  logic [HB-1:0] h_eff;
  logic [RB-1:0] h_plus1;
  logic          wrap;
  logic [CB-1:0] col_eff;
  logic [RB-1:0] row_eff;
  logic [WB-1:0] col_inc;

  // Zero reads as one, anything above the store limit saturates.
  always_comb begin
    if (frame_width_r == '0) begin
      w_eff = WB'(1);
    end else if (32'(frame_width_r) > MAX_WIDTH) begin
      w_eff = WB'(MAX_WIDTH);
    end else begin
      w_eff = WB'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      h_eff = HB'(1);
    end else if (32'(frame_height_r) > MAX_HEIGHT) begin
      h_eff = HB'(MAX_HEIGHT);
    end else begin
      h_eff = HB'(frame_height_r);
    end
  end

  assign h_plus1 = RB'(h_eff) + RB'(1);

  // A position outside the frame restarts it at the first pixel.
  assign wrap    = (WB'(col_r) >= w_eff) || (row_r > h_plus1)
                   || ((row_r == h_plus1) && (col_r != '0));
  assign col_eff = wrap ? '0 : col_r;
  assign row_eff = wrap ? '0 : row_r;
  assign col_inc = WB'(col_eff) + WB'(1);

  assign col = col_eff;

  // Classification of the item at the current position.
  always_comb begin
    ctrl.emit     = (row_eff >= RB'(2)) || ((row_eff == RB'(1)) && (col_eff != '0));
    ctrl.last     = (row_eff == h_plus1) && (col_eff == '0);
    ctrl.interior = (WB'(col_eff) >= WB'(2)) && (row_eff >= RB'(2))
                    && (row_eff < RB'(h_eff));
  end

  // Position advance, and restart on any register write.
  always_comb begin
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    col_nxt          = col_r;
    row_nxt          = row_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH: begin
          frame_width_nxt = cfg_data;
          col_nxt         = '0;
          row_nxt         = '0;
        end
        REG_FRAME_HEIGHT: begin
          frame_height_nxt = cfg_data;
          col_nxt          = '0;
          row_nxt          = '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      if (ctrl.last) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_inc >= w_eff) begin
        col_nxt = '0;
        row_nxt = row_eff + RB'(1);
      end else begin
        col_nxt = CB'(col_inc);
        row_nxt = row_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RESET;
      frame_height_r <= FRAME_HEIGHT_RESET;
      col_r          <= '0;
      row_r          <= '0;
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
      col_r          <= col_nxt;
      row_r          <= row_nxt;
    end
  end

endmodule

FILE: design/rbs_line_store.sv
// ----------------------------------------------------------------------------
// RGBA 3x3 blur stream: line stores
// Two row memories read when an item is accepted and written when it moves
// on; a bypass covers an item that reads the column its predecessor writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbs_line_store import rbs_pkg::*; #(
  parameter int unsigned MAX_WIDTH = RBS_MAX_WIDTH,
  localparam int unsigned CB = $clog2(MAX_WIDTH)
) (
  input  logic          clk,
  input  logic          accept,
  input  pixel_t        in_pix,
  input  logic [CB-1:0] in_col,
  input  logic          advance,
  output pixel_t        pix_upper,
  output pixel_t        pix_middle,
  output pixel_t        pix_new
);

  pixel_t upper_mem  [MAX_WIDTH];
  pixel_t middle_mem [MAX_WIDTH];

  pixel_t        rd_upper_r;
  pixel_t        rd_middle_r;
  pixel_t        pix_r;
  logic [CB-1:0] col_r;
  logic          bypass_r;
  pixel_t        wr_upper_r;
  pixel_t        wr_middle_r;

  // Read both rows at accept; the item's own data waits beside them.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_upper_r  <= upper_mem[in_col];
      rd_middle_r <= middle_mem[in_col];
      pix_r       <= in_pix;
      col_r       <= in_col;
      bypass_r    <= advance && (in_col == col_r);
    end
  end

  // A read that met a write to the same column takes the written data.
  assign pix_upper  = bypass_r ? wr_upper_r  : rd_upper_r;
  assign pix_middle = bypass_r ? wr_middle_r : rd_middle_r;
  assign pix_new    = pix_r;

  // Rows move up by one as the item leaves.
  always_ff @(posedge clk) begin
    if (advance) begin
      upper_mem[col_r] <= pix_middle;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      middle_mem[col_r] <= pix_r;
      wr_upper_r        <= pix_middle;
      wr_middle_r       <= pix_r;
    end
  end

endmodule

FILE: design/rbs_window_filter.sv
// ----------------------------------------------------------------------------
// RGBA 3x3 blur stream: window and kernel
// Keeps the 3x3 pixel window and works out the blurred value of its centre.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbs_window_filter import rbs_pkg::*; (
  input  logic   clk,
  input  logic   shift,
  input  pixel_t pix_upper,
  input  pixel_t pix_middle,
  input  pixel_t pix_new,
  output pixel_t blur_pix,
  output pixel_t centre_pix
);

  // Row-major window, newest column on the right.
  pixel_t win_r [9];

  always_ff @(posedge clk) begin
    if (shift) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= pix_upper;
      win_r[3] <= win_r[4];
      win_r[4] <= win_r[5];
      win_r[5] <= pix_middle;
      win_r[6] <= win_r[7];
      win_r[7] <= win_r[8];
      win_r[8] <= pix_new;
    end
  end

  // Four independent channels through the same kernel.
  always_comb begin
    blur_pix.red   = blur_chan(win_r[0].red,   win_r[1].red,   win_r[2].red,
                               win_r[3].red,   win_r[4].red,   win_r[5].red,
                               win_r[6].red,   win_r[7].red,   win_r[8].red);
    blur_pix.green = blur_chan(win_r[0].green, win_r[1].green, win_r[2].green,
                               win_r[3].green, win_r[4].green, win_r[5].green,
                               win_r[6].green, win_r[7].green, win_r[8].green);
    blur_pix.blue  = blur_chan(win_r[0].blue,  win_r[1].blue,  win_r[2].blue,
                               win_r[3].blue,  win_r[4].blue,  win_r[5].blue,
                               win_r[6].blue,  win_r[7].blue,  win_r[8].blue);
    blur_pix.alpha = blur_chan(win_r[0].alpha, win_r[1].alpha, win_r[2].alpha,
                               win_r[3].alpha, win_r[4].alpha, win_r[5].alpha,
                               win_r[6].alpha, win_r[7].alpha, win_r[8].alpha);
  end

  assign centre_pix = win_r[4];

endmodule

FILE: design/rgba_3x3_blur_stream.sv
// ----------------------------------------------------------------------------
// RGBA 3x3 blur stream
//   Channel  Direction  Handshake                    Payload
//   in       input      in_valid / in_ready          in_red, in_green, in_blue,
//                                                    in_alpha
//   out      output     out_valid / out_ready        out_red, out_green,
//                                                    out_blue, out_alpha,
//                                                    out_frame_last
//   cfg      input      cfg_we (no handshake back)   cfg_index, cfg_data
//
// One item per clock cycle sustained while the output is not stalled; an
// accepted item moves through the line store read and window stages in turn.
// The path is line store read, window shift, kernel and output register, and
// each stage moves on as soon as the stage after it is free or leaving.
// A stalled output holds the pipeline back stage by stage; empty stages fill.
// Reset empties the pipeline, clears the position and sets the size registers
// to their reset values; the line stores are not cleared and need no setup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "rgba_3x3_blur_stream_macros.svh"

module rgba_3x3_blur_stream import rbs_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = RBS_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = RBS_MAX_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_red,
  input  logic [7:0]           in_green,
  input  logic [7:0]           in_blue,
  input  logic [7:0]           in_alpha,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_red,
  output logic [7:0]           out_green,
  output logic [7:0]           out_blue,
  output logic [7:0]           out_alpha,
  output logic                 out_frame_last,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int unsigned CB = $clog2(MAX_WIDTH);

  logic          accept;
  logic [CB-1:0] col;
  item_ctrl_t    ctrl;
  pixel_t        in_pix;
  pixel_t        pix_upper, pix_middle, pix_new;
  pixel_t        blur_pix, centre_pix;

  logic       s1_valid_r, s1_valid_nxt;
  item_ctrl_t s1_ctrl_r;
  logic       s2_valid_r, s2_valid_nxt;
  item_ctrl_t s2_ctrl_r;
  logic       out_valid_r, out_valid_nxt;
  pixel_t     out_pix_r;
  logic       out_last_r;

  logic out_free, s2_go, s2_free, s1_go;

  // Stage flow: each stage moves when the next is empty or leaving.
  // An item that gives no result leaves the window stage without output.
  assign out_free = !out_valid_r || out_ready;
  assign s2_go    = s2_valid_r && (!s2_ctrl_r.emit || out_free);
  assign s2_free  = !s2_valid_r || s2_go;
  assign s1_go    = s1_valid_r && s2_free;
  assign in_ready = !s1_valid_r || s1_go;
  assign accept   = in_valid && in_ready;

  assign in_pix = '{alpha: in_alpha, blue: in_blue, green: in_green, red: in_red};

  rbs_frame_pos #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_pos (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .col       (col),
    .ctrl      (ctrl)
  );

  rbs_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_lines (
    .clk        (clk),
    .accept     (accept),
    .in_pix     (in_pix),
    .in_col     (col),
    .advance    (s1_go),
    .pix_upper  (pix_upper),
    .pix_middle (pix_middle),
    .pix_new    (pix_new)
  );

  rbs_window_filter u_filter (
    .clk        (clk),
    .shift      (s1_go),
    .pix_upper  (pix_upper),
    .pix_middle (pix_middle),
    .pix_new    (pix_new),
    .blur_pix   (blur_pix),
    .centre_pix (centre_pix)
  );

  // Stage valid flags.
  always_comb begin
    s1_valid_nxt = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);
    s2_valid_nxt = s1_go ? 1'b1 : (s2_go ? 1'b0 : s2_valid_r);
    if (s2_go && s2_ctrl_r.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Item classification travels with the item.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctrl_r <= ctrl;
    end
    if (s1_go) begin
      s2_ctrl_r <= s1_ctrl_r;
    end
  end

  // Output register: blurred interior, centre pixel on the border.
  always_ff @(posedge clk) begin
    if (s2_go && s2_ctrl_r.emit) begin
      out_pix_r  <= s2_ctrl_r.interior ? blur_pix : centre_pix;
      out_last_r <= s2_ctrl_r.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red        = out_pix_r.red;
  assign out_green      = out_pix_r.green;
  assign out_blue       = out_pix_r.blue;
  assign out_alpha      = out_pix_r.alpha;
  assign out_frame_last = out_last_r;

  // A waiting result is never overwritten.
  `RBS_ASSERT_NOW(a_no_overwrite, out_valid_r && !out_ready, !(s2_go && s2_ctrl_r.emit))
  // A blurred result is always one that is delivered.
  `RBS_ASSERT_NOW(a_interior_emits, s2_valid_r && s2_ctrl_r.interior, s2_ctrl_r.emit)
  // A result held back in the window stage is still there next cycle.
  `RBS_ASSERT_NEXT(a_s2_holds, s2_valid_r && s2_ctrl_r.emit && !s2_go, s2_valid_r && s2_ctrl_r.emit)

endmodule

FILE: test/rgba_3x3_blur_stream_tb.sv
// ----------------------------------------------------------------------------
// RGBA 3x3 blur stream testbench
// Streams frames of RGBA pixels into the blur and checks every result item
// against a behavioural predictor of the kernel, the border pass-through and
// the frame position. Directed tests cover the reset size, channel extremes,
// tiny frame sizes and register writes; a random stream of small frames
// follows. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgba_3x3_blur_stream_tb;
  import rbs_pkg::*;

  localparam int unsigned MAX_W        = RBS_MAX_WIDTH;
  localparam int unsigned MAX_H        = RBS_MAX_HEIGHT;
  localparam int unsigned PIPE_SETTLE  = 8;
  localparam int unsigned DRAIN_LIMIT  = 2000;
  localparam int unsigned RANDOM_ITEMS = 120;
  localparam int unsigned MAX_REPORTS  = 100;
  localparam longint      TIMEOUT_NS   = 150_000_000;

  // Indexes past the register list; writes to them must have no effect.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic   last;
    pixel_t px;
  } blur_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [7:0]           in_red;
  logic [7:0]           in_green;
  logic [7:0]           in_blue;
  logic [7:0]           in_alpha;
  logic                 out_valid;
  logic                 out_ready;
  logic [7:0]           out_red;
  logic [7:0]           out_green;
  logic [7:0]           out_blue;
  logic [7:0]           out_alpha;
  logic                 out_frame_last;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  // Predictor state: size registers, frame position, line stores, window.
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  int unsigned      col_pos;
  int unsigned      row_pos;
  pixel_t           upper_row [MAX_W];
  pixel_t           middle_row [MAX_W];
  pixel_t           window_px [9];

  blur_result_t expected_pixels [$];
  blur_result_t oldest_expected;
  int unsigned  error_count;
  int unsigned  results_seen;
  int unsigned  items_sent;
  int unsigned  calm_left;

  rgba_3x3_blur_stream u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_alpha       (in_alpha),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_alpha      (out_alpha),
    .out_frame_last (out_frame_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(TIMEOUT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  // A size register of zero reads as one; large values saturate.
  function automatic int unsigned clamp_size(input logic [CFG_W-1:0] v,
                                             input int unsigned hi);
    if (v == '0) return 1;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  // Pixels plus tail items that make up one whole frame.
  function automatic int unsigned frame_len();
    int unsigned w;
    w = clamp_size(width_reg, MAX_W);
    return w * clamp_size(height_reg, MAX_H) + w + 1;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    int     k;
    px = pixel_t'($urandom);
    // Some pixels are built from saturated channels only.
    if ($urandom_range(0, 4) == 0) begin
      for (k = 0; k < 4; k++) px[8*k +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end
    return px;
  endfunction

  function automatic logic [CFG_W-1:0] random_dim();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return '0;
    if (roll < 12) return CFG_W'($urandom_range(9, 24));
    return CFG_W'($urandom_range(1, 8));
  endfunction

  // Advance the predictor by one accepted item and queue any result it owes.
  task automatic blur_predict(input pixel_t px);
    int unsigned  w;
    int unsigned  h;
    int unsigned  c;
    int unsigned  r;
    int unsigned  i;
    int unsigned  k;
    int unsigned  sum;
    pixel_t       above;
    pixel_t       mid;
    logic         emit;
    logic         last;
    logic         interior;
    blur_result_t res;
    w = clamp_size(width_reg, MAX_W);
    h = clamp_size(height_reg, MAX_H);
    c = col_pos;
    r = row_pos;
    // A position outside the frame starts a fresh frame.
    if (c >= w || r > h + 1 || (r == h + 1 && c != 0)) begin
      c = 0;
      r = 0;
    end
    above = upper_row[c];
    mid = middle_row[c];
    upper_row[c] = mid;
    middle_row[c] = px;

    // Shift the window one column left and load the new column.
    for (i = 0; i < 3; i++) begin
      window_px[i*3] = window_px[i*3 + 1];
      window_px[i*3 + 1] = window_px[i*3 + 2];
    end
    window_px[2] = above;
    window_px[5] = mid;
    window_px[8] = px;

    emit = (r >= 2) || (r == 1 && c >= 1);
    last = (r == h + 1) && (c == 0);
    interior = (c >= 2) && (r >= 2) && (r + 1 <= h);

    if (last) begin
      col_pos = 0;
      row_pos = 0;
    end else if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end

    if (emit) begin
      res.last = last;
      for (k = 0; k < 4; k++) begin
        if (interior) begin
          sum = window_px[0][8*k +: 8] + window_px[2][8*k +: 8]
              + window_px[6][8*k +: 8] + window_px[8][8*k +: 8]
              + 4 * (window_px[1][8*k +: 8] + window_px[3][8*k +: 8]
                   + window_px[5][8*k +: 8] + window_px[7][8*k +: 8])
              + 20 * window_px[4][8*k +: 8];
          res.px[8*k +: 8] = 8'(sum / 40);
        end else begin
          res.px[8*k +: 8] = window_px[4][8*k +: 8];
        end
      end
      expected_pixels.push_back(res);
    end
  endtask

  // Offer one item, with a random gap first, and hold it until accepted.
  task automatic send_pixel(input pixel_t px);
    int unsigned gap;
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(30, 150);
      gap = pick_gap();
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_red   <= px.red;
    in_green <= px.green;
    in_blue  <= px.blue;
    in_alpha <= px.alpha;
    do @(posedge clk); while (!in_ready);
    blur_predict(px);
    items_sent++;
  endtask

  task automatic send_random_pixels(input int unsigned count);
    repeat (count) send_pixel(random_pixel());
  endtask

  task automatic send_frames(input int unsigned count);
    repeat (count) send_random_pixels(frame_len());
  endtask

  // Stop offering items, collect every owed result and let the pipeline empty.
  task automatic quiesce();
    int unsigned waited;
    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (expected_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_pixels.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived",
                                expected_pixels.size()));
      expected_pixels.delete();
    end
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  // Register write; the caller makes sure the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH: begin
        width_reg = data;
        col_pos = 0;
        row_pos = 0;
      end
      REG_FRAME_HEIGHT: begin
        height_reg = data;
        col_pos = 0;
        row_pos = 0;
      end
      default: ;
    endcase
  endtask

  task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    quiesce();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
  endtask

  // The reset width decides where the first row ends and results begin.
  task automatic test_reset_size();
    send_random_pixels(FRAME_WIDTH_RESET + 6);
  endtask

  // Saturated and empty channels through a single interior pixel.
  task automatic test_pixel_extremes();
    pixel_t pattern;
    int     i;
    set_frame(12'd3, 12'd3);
    repeat (9) send_pixel('1);
    repeat (4) send_pixel('0);
    pattern = {8'h00, 8'hFF, 8'h55, 8'hAA};
    for (i = 0; i < 9; i++) send_pixel((i % 2 == 0) ? pattern : pixel_t'(~pattern));
    repeat (4) send_pixel('1);
  endtask

  // Zero sizes read as one; frames under three rows or columns are all border.
  task automatic test_tiny_frames();
    set_frame(12'd0, 12'd0);
    send_frames(2);
    set_frame(12'd1, 12'd5);
    send_frames(1);
    set_frame(12'd2, 12'd4);
    send_frames(1);
    set_frame(12'd5, 12'd2);
    send_frames(1);
    set_frame(12'd6, 12'd1);
    send_frames(1);
  endtask

  // Real register writes restart the frame; writes to spare indexes do not.
  task automatic test_register_writes();
    int unsigned remaining;
    set_frame(12'd4, 12'd4);
    send_random_pixels(7);
    quiesce();
    write_reg(REG_FRAME_WIDTH, 12'd4);
    send_frames(1);
    send_random_pixels(5);
    quiesce();
    write_reg(REG_FRAME_HEIGHT, 12'd3);
    send_frames(1);
    send_random_pixels(6);
    remaining = frame_len() - 6;
    quiesce();
    write_reg(REG_SPARE_LO, CFG_W'($urandom));
    write_reg(REG_SPARE_HI, '1);
    send_random_pixels(remaining);
    send_frames(1);
  endtask

  // Mostly whole frames back to back, with some frames cut short by a write.
  task automatic test_random_stream();
    int unsigned target;
    int unsigned roll;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 25) set_frame(random_dim(), random_dim());
      if (roll >= 85) begin
        send_random_pixels($urandom_range(1, frame_len() - 1));
        quiesce();
        write_reg($urandom_range(0, 1) ? REG_FRAME_WIDTH : REG_FRAME_HEIGHT,
                  random_dim());
      end else begin
        send_frames($urandom_range(1, 3));
      end
    end
  endtask

  // Result side back-pressure: ready runs broken by stalls of random length.
  initial begin
    int unsigned hold;
    int unsigned stall;
    forever begin
      hold = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                         : $urandom_range(1, 8);
      stall = pick_gap();
      out_ready <= 1'b1;
      repeat (hold) @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  // Compare each accepted result item with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with none expected", results_seen));
      end else begin
        oldest_expected = expected_pixels.pop_front();
        if (out_red !== oldest_expected.px.red)
          report_mismatch($sformatf("result %0d red %0d, expected %0d",
                                    results_seen, out_red, oldest_expected.px.red));
        if (out_green !== oldest_expected.px.green)
          report_mismatch($sformatf("result %0d green %0d, expected %0d",
                                    results_seen, out_green, oldest_expected.px.green));
        if (out_blue !== oldest_expected.px.blue)
          report_mismatch($sformatf("result %0d blue %0d, expected %0d",
                                    results_seen, out_blue, oldest_expected.px.blue));
        if (out_alpha !== oldest_expected.px.alpha)
          report_mismatch($sformatf("result %0d alpha %0d, expected %0d",
                                    results_seen, out_alpha, oldest_expected.px.alpha));
        if (out_frame_last !== oldest_expected.last)
          report_mismatch($sformatf("result %0d frame_last %0b, expected %0b",
                                    results_seen, out_frame_last, oldest_expected.last));
      end
    end
  end

  // Main sequence.
  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_red    = '0;
    in_green  = '0;
    in_blue   = '0;
    in_alpha  = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_data  = '0;
    width_reg = FRAME_WIDTH_RESET;
    height_reg = FRAME_HEIGHT_RESET;
    col_pos = 0;
    row_pos = 0;
    error_count = 0;
    results_seen = 0;
    items_sent = 0;
    calm_left = 0;
    for (int i = 0; i < MAX_W; i++) begin
      upper_row[i] = '0;
      middle_row[i] = '0;
    end
    for (int i = 0; i < 9; i++) window_px[i] = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_size();
    test_pixel_extremes();
    test_tiny_frames();
    test_register_writes();
    test_random_stream();

    quiesce();
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
